### src/serial_grid_led_command_decoder_top_defines.svh
// Shared assertion macros
`ifndef SERIAL_GRID_LED_COMMAND_DECODER_TOP_DEFINES_SVH
`define SERIAL_GRID_LED_COMMAND_DECODER_TOP_DEFINES_SVH
`define SGL_ASSERT_IMP(label, clk_s, rst_n, a, c, msg) \
label: assert property (@(posedge clk_s) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define SGL_ASSERT_NXT(label, clk_s, rst_n, a, c, msg) \
label: assert property (@(posedge clk_s) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

### src/sgl_pkg.sv
`default_nettype none
package sgl_pkg;
	localparam int LED_COUNT_DEF = 256;
	localparam int NAME_BYTES = 32;
	localparam int RING_LEDS = 64;

	localparam logic [1:0] KIND_RESP = 2'd0;
	localparam logic [1:0] KIND_KEY = 2'd1;
	localparam logic [1:0] KIND_DELTA = 2'd2;
	localparam logic [1:0] KIND_LEVEL = 2'd3;

	localparam logic [7:0] OP_QUERY = 8'h00;
	localparam logic [7:0] OP_ID = 8'h01;
	localparam logic [7:0] OP_NAME = 8'h02;
	localparam logic [7:0] OP_GRIDQ = 8'h03;
	localparam logic [7:0] OP_SIZE = 8'h05;
	localparam logic [7:0] OP_OFF = 8'h10;
	localparam logic [7:0] OP_ON = 8'h11;
	localparam logic [7:0] OP_ALL0 = 8'h12;
	localparam logic [7:0] OP_ALL1 = 8'h13;
	localparam logic [7:0] OP_MAP = 8'h14;
	localparam logic [7:0] OP_ROW = 8'h15;
	localparam logic [7:0] OP_COL = 8'h16;
	localparam logic [7:0] OP_LALL = 8'h17;
	localparam logic [7:0] OP_LSET = 8'h18;
	localparam logic [7:0] OP_LALL2 = 8'h19;
	localparam logic [7:0] OP_LMAP = 8'h1A;
	localparam logic [7:0] OP_LROW = 8'h1B;
	localparam logic [7:0] OP_LCOL = 8'h1C;
	localparam logic [7:0] OP_KUP = 8'h20;
	localparam logic [7:0] OP_KDN = 8'h21;
	localparam logic [7:0] OP_DELTA = 8'h50;
	localparam logic [7:0] OP_ASET = 8'h90;
	localparam logic [7:0] OP_AALL = 8'h91;
	localparam logic [7:0] OP_AMAP = 8'h92;
	localparam logic [7:0] OP_ARANGE = 8'h93;

	localparam logic [1:0] REG_ROWS = 2'd0;
	localparam logic [1:0] REG_COLS = 2'd1;
	localparam logic [1:0] REG_THR = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE, ST_RESP, ST_NAMERD, ST_NAMEOUT, ST_FILL, ST_WRITE, ST_LOOP,
		ST_PAIR, ST_READ, ST_READOUT
	} state_t;

	typedef enum logic [2:0] {
		WS_NONE, WS_GRID, WS_ARC, WS_ALL
	} wsel_t;

	typedef struct packed {
		logic       arg_we;
		logic [1:0] arg_idx;
		logic       name_we;
		logic [4:0] name_idx;
		logic       wr_en;
		wsel_t      wsel;
		logic [8:0] wx;
		logic [8:0] wy;
		logic [7:0] wlevel;
		logic       rd_name;
		logic       rd_led;
		logic [7:0] rd_idx;
	} dp_cmd_t;

	function automatic logic [5:0] cmd_length(input logic [7:0] op);
		case (op)
			8'h17, 8'h19, 8'h51, 8'h52: cmd_length = 6'd2;
			8'h06, 8'h08, 8'h10, 8'h11, 8'h15, 8'h16, 8'h20, 8'h21, 8'h50,
			8'h91: cmd_length = 6'd3;
			8'h04, 8'h18, 8'h90: cmd_length = 6'd4;
			8'h93: cmd_length = 6'd5;
			8'h1B, 8'h1C: cmd_length = 6'd7;
			8'h0F: cmd_length = 6'd9;
			8'h14: cmd_length = 6'd11;
			8'h02: cmd_length = 6'd33;
			8'h92: cmd_length = 6'd34;
			8'h1A: cmd_length = 6'd35;
			default: cmd_length = 6'd1;
		endcase
	endfunction

	function automatic logic [8:0] wrap_block(input logic [7:0] v);
		logic [7:0] w;
		begin
			w = (v > 8'd16) ? (v & 8'h0F) : v;
			wrap_block = {1'b0, w & 8'hF8};
		end
	endfunction
endpackage
`default_nettype wire

### src/sgl_datapath.sv
`default_nettype none
`include "serial_grid_led_command_decoder_top_defines.svh"
module sgl_datapath import sgl_pkg::*; #(
	parameter int LED_COUNT = LED_COUNT_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire dp_cmd_t    cmd,
	input  wire logic [7:0] arg_data,
	input  wire logic [4:0] grid_rows,
	input  wire logic [4:0] grid_columns,
	output logic [7:0]      arg_q [4],
	output logic [7:0]      rd_data_q
);
	localparam int AW = $clog2(LED_COUNT);
	logic [7:0] led_mem [LED_COUNT];
	logic [7:0] name_mem [NAME_BYTES];
	logic [13:0] gidx;
	logic [15:0] aidx;
	logic        hit;
	logic [AW-1:0] waddr;

	always_comb begin
		gidx = 14'(cmd.wy) * 14'(grid_columns) + 14'(cmd.wx);
		aidx = 16'(cmd.wy) * 16'(RING_LEDS) + 16'(cmd.wx);
		hit = 1'b0;
		waddr = '0;
		case (cmd.wsel)
			WS_GRID: begin
				hit = (cmd.wx < 9'(grid_columns)) && (cmd.wy < 9'(grid_rows))
					&& (gidx < 14'(LED_COUNT));
				waddr = gidx[AW-1:0];
			end
			WS_ARC: begin
				hit = aidx < 16'(LED_COUNT);
				waddr = aidx[AW-1:0];
			end
			WS_ALL: begin
				hit = 1'b1;
				waddr = AW'({cmd.wy, cmd.wx});
			end
			default: hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en && hit)
			led_mem[waddr] <= cmd.wlevel;
		if (cmd.rd_name)
			rd_data_q <= name_mem[cmd.name_idx];
		else if (cmd.rd_led)
			rd_data_q <= (int'(cmd.rd_idx) < LED_COUNT) ? led_mem[AW'(cmd.rd_idx)] : 8'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++)
				arg_q[i] <= 8'd0;
			for (int i = 0; i < NAME_BYTES; i++)
				name_mem[i] <= 8'd0;
		end else begin
			if (cmd.arg_we)
				arg_q[cmd.arg_idx] <= arg_data;
			if (cmd.name_we)
				name_mem[cmd.name_idx] <= arg_data;
		end
	end

	`SGL_ASSERT_IMP(a_one_read, clk, arst_n, cmd.rd_name, !cmd.rd_led, "two reads")
	`SGL_ASSERT_IMP(a_no_rw_name, clk, arst_n, cmd.name_we, !cmd.rd_name, "name rw")
	`SGL_ASSERT_IMP(a_wsel, clk, arst_n, cmd.wr_en, cmd.wsel != WS_NONE, "write no sel")
endmodule
`default_nettype wire

### src/sgl_controller.sv
`default_nettype none
`include "serial_grid_led_command_decoder_top_defines.svh"
module sgl_controller import sgl_pkg::*; #(
	parameter int LED_COUNT = LED_COUNT_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic       func,
	input  wire logic [7:0] byte_in,
	input  wire logic [7:0] led_index,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [1:0]      kind,
	output logic [7:0]      out_byte,
	output logic [7:0]      key_x,
	output logic [7:0]      key_y,
	output logic            key_pressed,
	output logic [7:0]      arc_ring,
	output logic signed [7:0] arc_delta,
	output logic [7:0]      led_level,
	output logic            last,
	input  wire logic [4:0] grid_rows,
	input  wire logic [4:0] grid_columns,
	input  wire logic [3:0] mono_threshold,
	input  wire logic [7:0] arg_q [4],
	input  wire logic [7:0] rd_data_q,
	output dp_cmd_t         cmd,
	output logic [7:0]      arg_data
);
	localparam int CW = ($clog2(LED_COUNT + 1) < 9) ? 9 : $clog2(LED_COUNT + 1);
	state_t state_q, state_d;
	logic [7:0] code_q, code_d;
	logic [5:0] rem_q, rem_d;
	logic [5:0] pos_q, pos_d;
	logic [7:0] byte_q, byte_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [8:0] lim_q, lim_d;
	logic [1:0] step_q, step_d;
	logic       ended_q, ended_d;
	logic [4:0] quads_q, quads_d;
	logic [4:0] qrem_q, qrem_d;
	logic       ov_q, ov_d;
	logic [1:0] okind_q, okind_d;
	logic [7:0] ob_q, ob_d, kx_q, kx_d, ky_q, ky_d, ar_q, ar_d, ad_q, ad_d, lv_q, lv_d;
	logic       kp_q, kp_d, last_q, last_d;
	logic [5:0] z;
	logic [3:0] nib;
	logic [7:0] thr;
	logic       take;
	logic [5:0] len;

	assign in_stall = (state_q != ST_IDLE) || ov_q;
	assign take = in_valid && !in_stall;
	assign len = cmd_length(byte_in);
	assign out_valid = ov_q;
	assign kind = okind_q;
	assign out_byte = ob_q;
	assign key_x = kx_q;
	assign key_y = ky_q;
	assign key_pressed = kp_q;
	assign arc_ring = ar_q;
	assign arc_delta = ad_q;
	assign led_level = lv_q;
	assign last = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
			code_q <= '0; rem_q <= '0; pos_q <= '0; byte_q <= '0; cnt_q <= '0;
			lim_q <= '0; step_q <= '0; ended_q <= 1'b0; quads_q <= '0; qrem_q <= '0;
			ov_q <= 1'b0; okind_q <= '0; ob_q <= '0; kx_q <= '0; ky_q <= '0;
			ar_q <= '0; ad_q <= '0; lv_q <= '0; kp_q <= 1'b0; last_q <= 1'b0;
		end else begin
			state_q <= state_d;
			code_q <= code_d; rem_q <= rem_d; pos_q <= pos_d; byte_q <= byte_d;
			cnt_q <= cnt_d; lim_q <= lim_d; step_q <= step_d; ended_q <= ended_d;
			quads_q <= quads_d; qrem_q <= qrem_d; ov_q <= ov_d; okind_q <= okind_d;
			ob_q <= ob_d; kx_q <= kx_d; ky_q <= ky_d; ar_q <= ar_d; ad_q <= ad_d;
			lv_q <= lv_d; kp_q <= kp_d; last_q <= last_d;
		end
	end

	always_comb begin
		state_d = state_q; code_d = code_q; rem_d = rem_q; pos_d = pos_q;
		byte_d = byte_q; cnt_d = cnt_q; lim_d = lim_q; step_d = step_q;
		ended_d = ended_q; quads_d = quads_q; qrem_d = qrem_q; ov_d = ov_q;
		okind_d = okind_q; ob_d = ob_q; kx_d = kx_q; ky_d = ky_q; ar_d = ar_q;
		ad_d = ad_q; lv_d = lv_q; kp_d = kp_q; last_d = last_q;
		cmd = '0;
		cmd.wsel = WS_NONE;
		arg_data = byte_in;
		z = '0; nib = '0; thr = '0;
		if (ov_q && !out_stall)
			ov_d = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (take && func) begin
					cmd.rd_led = 1'b1;
					cmd.rd_idx = led_index;
					state_d = ST_READOUT;
				end else if (take) begin
					if (rem_q == 6'd0) begin
						code_d = byte_in;
						pos_d = '0;
						if (len == 6'd1) begin
							cnt_d = '0;
							step_d = '0;
							quads_d = '0;
							qrem_d = grid_columns;
							case (byte_in)
								OP_QUERY, OP_GRIDQ, OP_SIZE: state_d = ST_RESP;
								OP_ID: state_d = ST_RESP;
								OP_ALL0, OP_ALL1: state_d = ST_FILL;
								default: code_d = OP_QUERY;
							endcase
							if (byte_in != OP_QUERY && state_d == ST_IDLE)
								code_d = '0;
						end else begin
							rem_d = len - 6'd1;
						end
					end else begin
						byte_d = byte_in;
						rem_d = rem_q - 6'd1;
						pos_d = pos_q + 6'd1;
						cnt_d = '0;
						step_d = '0;
						case (code_q)
							OP_NAME: begin
								if (pos_q < 6'(NAME_BYTES)) begin
									cmd.name_we = 1'b1;
									cmd.name_idx = pos_q[4:0];
								end
							end
							OP_MAP, OP_LMAP, OP_LROW, OP_LCOL: begin
								if (pos_q < 6'd2) begin
									cmd.arg_we = 1'b1;
									cmd.arg_idx = pos_q[1:0];
								end else begin
									state_d = (code_q == OP_MAP) ? ST_LOOP : ST_PAIR;
								end
							end
							OP_AMAP: begin
								if (pos_q < 6'd1) begin
									cmd.arg_we = 1'b1;
									cmd.arg_idx = 2'd0;
								end else begin
									state_d = ST_PAIR;
								end
							end
							default: begin
								if (pos_q < 6'd4) begin
									cmd.arg_we = 1'b1;
									cmd.arg_idx = pos_q[1:0];
								end
							end
						endcase
						if (rem_q == 6'd1 && state_d == ST_IDLE)
							state_d = ST_WRITE;
					end
				end
			end
			ST_LOOP: begin
				cmd.wr_en = 1'b1;
				cmd.wsel = WS_GRID;
				cmd.wlevel = byte_q[cnt_q[2:0]] ? 8'd15 : 8'd0;
				case (code_q)
					OP_ROW: begin
						cmd.wx = wrap_block(arg_q[0]) + 9'(cnt_q[2:0]);
						cmd.wy = {1'b0, arg_q[1]};
						cmd.wlevel = arg_q[2][cnt_q[2:0]] ? 8'd15 : 8'd0;
					end
					OP_COL: begin
						cmd.wx = {1'b0, arg_q[0]};
						cmd.wy = wrap_block(arg_q[1]) + 9'(cnt_q[2:0]);
						cmd.wlevel = arg_q[2][cnt_q[2:0]] ? 8'd15 : 8'd0;
					end
					OP_AALL: begin
						cmd.wsel = WS_ARC;
						cmd.wx = 9'(cnt_q);
						cmd.wy = {1'b0, arg_q[0]};
						cmd.wlevel = arg_q[1];
					end
					OP_ARANGE: begin
						cmd.wsel = WS_ARC;
						cmd.wx = 9'(cnt_q);
						cmd.wy = {1'b0, arg_q[0]};
						cmd.wlevel = arg_q[3];
					end
					default: begin
						cmd.wx = wrap_block(arg_q[0]) + 9'(cnt_q[2:0]);
						cmd.wy = wrap_block(arg_q[1]) + 9'(pos_q - 6'd3);
					end
				endcase
				if (code_q == OP_ARANGE) begin
					if (cnt_q >= CW'(lim_q)) begin
						cmd.wr_en = 1'b0;
						if (step_q == 2'd0 && !(arg_q[1] < arg_q[2])) begin
							step_d = 2'd1;
							cnt_d = '0;
							lim_d = {1'b0, arg_q[2]};
						end else begin
							state_d = ST_IDLE;
						end
					end else begin
						cnt_d = cnt_q + 1'b1;
					end
				end else begin
					cnt_d = cnt_q + 1'b1;
					if (cnt_q == ((code_q == OP_AALL) ? CW'(RING_LEDS - 1) : CW'(7)))
						state_d = ST_IDLE;
				end
				if (state_d == ST_IDLE && rem_q == 6'd0) begin
					code_d = '0;
					pos_d = '0;
				end
			end
			ST_PAIR: begin
				cmd.wr_en = 1'b1;
				cmd.wsel = WS_GRID;
				z = ((pos_q - ((code_q == OP_AMAP) ? 6'd2 : 6'd3)) << 1) + 6'(step_q[0]);
				nib = step_q[0] ? byte_q[3:0] : byte_q[7:4];
				thr = (nib > mono_threshold) ? {4'd0, nib} : 8'd0;
				cmd.wlevel = thr;
				case (code_q)
					OP_LMAP: begin
						cmd.wx = wrap_block(arg_q[0]) + 9'(z[2:0]);
						cmd.wy = wrap_block(arg_q[1]) + 9'(z[5:3]);
					end
					OP_LROW: begin
						cmd.wx = wrap_block(arg_q[0]) + 9'(z);
						cmd.wy = wrap_block(arg_q[1]);
					end
					OP_LCOL: begin
						cmd.wx = wrap_block(arg_q[0]);
						cmd.wy = wrap_block(arg_q[1]) + 9'(z);
					end
					default: begin
						cmd.wsel = WS_ARC;
						cmd.wx = 9'(z);
						cmd.wy = {1'b0, arg_q[0]};
						cmd.wlevel = {4'd0, nib};
					end
				endcase
				step_d = step_q + 2'd1;
				if (step_q[0]) begin
					state_d = ST_IDLE;
					if (rem_q == 6'd0) begin
						code_d = '0;
						pos_d = '0;
					end
				end
			end
			ST_WRITE: begin
				state_d = ST_IDLE;
				code_d = '0;
				pos_d = '0;
				cnt_d = '0;
				step_d = '0;
				case (code_q)
					OP_OFF, OP_ON, OP_LSET: begin
						cmd.wr_en = 1'b1;
						cmd.wsel = WS_GRID;
						cmd.wx = {1'b0, arg_q[0]};
						cmd.wy = {1'b0, arg_q[1]};
						cmd.wlevel = (code_q == OP_OFF) ? 8'd0 :
							(code_q == OP_ON) ? 8'd15 : arg_q[2];
					end
					OP_ASET: begin
						cmd.wr_en = 1'b1;
						cmd.wsel = WS_ARC;
						cmd.wx = {1'b0, arg_q[1]};
						cmd.wy = {1'b0, arg_q[0]};
						cmd.wlevel = arg_q[2];
					end
					OP_LALL, OP_LALL2: begin
						state_d = ST_FILL;
						code_d = code_q;
					end
					OP_ROW, OP_COL, OP_AALL: begin
						state_d = ST_LOOP;
						code_d = code_q;
					end
					OP_ARANGE: begin
						state_d = ST_LOOP;
						code_d = code_q;
						cnt_d = CW'(arg_q[1]);
						lim_d = (arg_q[1] < arg_q[2]) ? {1'b0, arg_q[2]} : 9'(RING_LEDS);
					end
					OP_KUP, OP_KDN: begin
						ov_d = 1'b1; okind_d = KIND_KEY; last_d = 1'b1;
						ob_d = '0; kx_d = arg_q[0]; ky_d = arg_q[1];
						kp_d = (code_q == OP_KDN); ar_d = '0; ad_d = '0; lv_d = '0;
					end
					OP_DELTA: begin
						ov_d = 1'b1; okind_d = KIND_DELTA; last_d = 1'b1;
						ob_d = '0; kx_d = '0; ky_d = '0; kp_d = 1'b0;
						ar_d = arg_q[0]; ad_d = arg_q[1]; lv_d = '0;
					end
					default: ;
				endcase
			end
			ST_FILL: begin
				cmd.wr_en = 1'b1;
				cmd.wsel = WS_ALL;
				{cmd.wy, cmd.wx} = 18'(cnt_q);
				cmd.wlevel = (code_q == OP_ALL0) ? 8'd0 :
					(code_q == OP_ALL1) ? 8'd15 : arg_q[0];
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == CW'(LED_COUNT - 1)) begin
					state_d = ST_IDLE;
					code_d = '0;
				end
			end
			ST_RESP: begin
				if (code_q == OP_QUERY && qrem_q >= grid_rows && grid_rows != 5'd0) begin
					qrem_d = qrem_q - grid_rows;
					quads_d = quads_q + 5'd1;
				end else if (!ov_q || !out_stall) begin
					ov_d = 1'b1; okind_d = KIND_RESP; ob_d = '0; kx_d = '0; ky_d = '0;
					kp_d = 1'b0; ar_d = '0; ad_d = '0; lv_d = '0; last_d = 1'b0;
					cnt_d = cnt_q + 1'b1;
					case (code_q)
						OP_QUERY: begin
							case (cnt_q[2:0])
								3'd1: ob_d = 8'd1;
								3'd2, 3'd5: ob_d = {3'd0, quads_q};
								3'd4: ob_d = 8'd2;
								default: ob_d = 8'd0;
							endcase
							last_d = (cnt_q[2:0] == 3'd5);
						end
						OP_GRIDQ: begin
							ob_d = (cnt_q[1:0] == 2'd0) ? 8'd2 :
								(cnt_q[1:0] == 2'd1) ? 8'd1 : 8'd0;
							last_d = (cnt_q[1:0] == 2'd3);
						end
						OP_SIZE: begin
							ob_d = (cnt_q[1:0] == 2'd0) ? 8'd3 :
								(cnt_q[1:0] == 2'd1) ? {3'd0, grid_columns} :
								{3'd0, grid_rows};
							last_d = (cnt_q[1:0] == 2'd2);
						end
						default: begin
							ob_d = 8'd1;
							ended_d = 1'b0;
							state_d = ST_NAMERD;
							cnt_d = '0;
						end
					endcase
					if (last_d) begin
						state_d = ST_IDLE;
						code_d = '0;
					end
				end
			end
			ST_NAMERD: begin
				cmd.rd_name = 1'b1;
				cmd.name_idx = cnt_q[4:0];
				state_d = ST_NAMEOUT;
			end
			ST_NAMEOUT: begin
				if (!ov_q || !out_stall) begin
					ov_d = 1'b1; okind_d = KIND_RESP;
					ended_d = ended_q || (rd_data_q == 8'd0);
					ob_d = ended_d ? 8'd0 : rd_data_q;
					last_d = (cnt_q == CW'(NAME_BYTES - 1));
					cnt_d = cnt_q + 1'b1;
					if (last_d) begin
						state_d = ST_IDLE;
						code_d = '0;
					end else begin
						state_d = ST_NAMERD;
					end
				end
			end
			ST_READOUT: begin
				ov_d = 1'b1; okind_d = KIND_LEVEL; ob_d = '0; kx_d = '0; ky_d = '0;
				kp_d = 1'b0; ar_d = '0; ad_d = '0; lv_d = rd_data_q; last_d = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	`SGL_ASSERT_IMP(a_idle_take, clk, arst_n, take, state_q == ST_IDLE, "take busy")
	`SGL_ASSERT_NXT(a_read_out, clk, arst_n, take && func, state_q == ST_READOUT,
		"read lost")
	`SGL_ASSERT_IMP(a_hold, clk, arst_n, ov_q && out_stall, ov_d, "result dropped")
endmodule
`default_nettype wire

### src/sgl_cfg_regs.sv
`default_nettype none
module sgl_cfg_regs import sgl_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	output logic [4:0]       grid_rows,
	output logic [4:0]       grid_columns,
	output logic [3:0]       mono_threshold
);
	logic [4:0] rows_q, cols_q;
	logic [3:0] thr_q;
	logic       we;
	assign pready = 1'b1;
	assign we = psel && penable && pwrite;
	assign grid_rows = rows_q;
	assign grid_columns = cols_q;
	assign mono_threshold = thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= '0; cols_q <= '0; thr_q <= '0;
		end else if (we && paddr[1:0] == 2'd0 && paddr[3:2] == REG_ROWS) begin
			rows_q <= pwdata[4:0];
		end else if (we && paddr[1:0] == 2'd0 && paddr[3:2] == REG_COLS) begin
			cols_q <= pwdata[4:0];
		end else if (we && paddr[1:0] == 2'd0 && paddr[3:2] == REG_THR) begin
			thr_q <= pwdata[3:0];
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_ROWS: prdata = {27'd0, rows_q};
			REG_COLS: prdata = {27'd0, cols_q};
			REG_THR:  prdata = {28'd0, thr_q};
			default:  prdata = 32'd0;
		endcase
	end
endmodule
`default_nettype wire

### src/serial_grid_led_command_decoder_top.sv
`default_nettype none
// Serial grid/arc LED command decoder. Host bytes (func 0) are parsed into
// fixed-length commands; a level read (func 1) registers the LED memory entry
// and then the result in the read-out state. After reset the block clears
// every LED memory entry, one entry per cycle, and stalls its input meanwhile.
// Pattern bytes are written as two levels each (level pairs) or eight bits
// each (bit maps); row and column writes set eight LEDs, arc ring writes a
// whole ring, arc range writes a run of arc positions, and fill commands every
// LED. Responses go out one item per cycle when not stalled; the status query
// first divides by repeated subtraction, and the name query reads each name
// entry in a read state before sending it. The next item is taken only after
// every result of the previous one has left.
module serial_grid_led_command_decoder_top import sgl_pkg::*; #(
	parameter int LED_COUNT = LED_COUNT_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        func,
	input  wire logic [7:0]  byte_in,
	input  wire logic [7:0]  led_index,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       kind,
	output logic [7:0]       out_byte,
	output logic [7:0]       key_x,
	output logic [7:0]       key_y,
	output logic             key_pressed,
	output logic [7:0]       arc_ring,
	output logic signed [7:0] arc_delta,
	output logic [7:0]       led_level,
	output logic             last,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	logic [4:0] grid_rows, grid_columns;
	logic [3:0] mono_threshold;
	logic [7:0] arg_q [4];
	logic [7:0] rd_data_q;
	logic [7:0] arg_data;
	dp_cmd_t    cmd;

	sgl_cfg_regs u_cfg (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.grid_rows, .grid_columns, .mono_threshold
	);

	sgl_controller #(.LED_COUNT(LED_COUNT)) u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .func, .byte_in, .led_index,
		.out_valid, .out_stall, .kind, .out_byte, .key_x, .key_y, .key_pressed,
		.arc_ring, .arc_delta, .led_level, .last, .grid_rows, .grid_columns,
		.mono_threshold, .arg_q, .rd_data_q, .cmd, .arg_data
	);

	sgl_datapath #(.LED_COUNT(LED_COUNT)) u_dp (
		.clk, .arst_n, .cmd, .arg_data, .grid_rows, .grid_columns, .arg_q, .rd_data_q
	);
endmodule
`default_nettype wire
